FILE: src/rtc_registers_to_epoch_top_macros.svh
// Assertion helpers for the RTC epoch converter.
`ifndef RTC_REGISTERS_TO_EPOCH_TOP_MACROS_SVH
`define RTC_REGISTERS_TO_EPOCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define RTE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rtc epoch check failed");
// Checked at every edge, reset included.
`define RTE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rtc epoch check failed");
`else
`define RTE_ASSERT(label, clk, rst, prop)
`define RTE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: src/rte_pkg.sv
package rte_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam int unsigned YEAR_MIN = 19;
  localparam int unsigned YEAR_MAX = 99;

  // 2000-03-01 era base (5 * 146097) minus the 1970 offset (719468)
  localparam logic [15:0] DAYS_OFFSET = 16'(5 * 146097 - 719468);

  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
  endfunction

  function automatic logic [7:0] bcd_val(input logic [7:0] v);
    return 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
  endfunction

  // day of the March-based year on which a month starts
  function automatic logic [8:0] doy_base(input logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/rtc_registers_to_epoch_top.sv
// RTC time registers to Unix epoch seconds. Pulse start with a snapshot of
// the six BCD clock registers; at the last stage done is high for exactly one
// cycle with status (0 ok, 1 oscillator halted, 2 bad register contents) and
// the UTC epoch, which is zero unless status is ok. The converter is a
// four-stage pipeline, so a new item may be started every cycle and busy is
// never raised; there is no way to hold results back, so the receiver must
// take done/status/epoch_seconds in the cycle they appear. The time-zone
// offset (local minus UTC, signed minutes) is written through cfg_we and
// cfg_wdata and should only change while no item is in flight. The day of
// the month is not checked against the month length; an out-of-range day
// simply runs into the next month.
`include "rtc_registers_to_epoch_top_macros.svh"

module rtc_registers_to_epoch_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  seconds_reg,
  input  logic [7:0]  minutes_reg,
  input  logic [7:0]  hours_reg,
  input  logic [7:0]  date_reg,
  input  logic [7:0]  month_reg,
  input  logic [7:0]  year_reg,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] epoch_seconds
);
  import rte_pkg::*;

  // Pipeline never stalls: the only downstream is a strobe.
  assign busy = 1'b0;

  // ---------------- configuration ----------------
  logic signed [10:0] tz_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_offset <= '0;
    end else if (cfg_we) begin
      tz_offset <= cfg_wdata;
    end
  end

  // ---------------- stage 1: BCD decode and range checks ----------------
  logic       twelve;
  logic [7:0] sec_b, min_b, hr_b, mon_b;
  logic [7:0] sec_v, min_v, hr_v, day_v, mon_v, yr_v;
  logic       digits_ok, hour_ok, range_ok;
  logic [4:0] hour24;
  status_t    status1_next;

  always_comb begin
    twelve = hours_reg[6];
    sec_b  = {1'b0, seconds_reg[6:0]};
    min_b  = {1'b0, minutes_reg[6:0]};
    hr_b   = twelve ? {3'd0, hours_reg[4:0]} : {2'd0, hours_reg[5:0]};
    mon_b  = {3'd0, month_reg[4:0]};

    digits_ok = bcd_ok(sec_b) && bcd_ok(min_b) && bcd_ok(hr_b)
             && bcd_ok(date_reg) && bcd_ok(mon_b) && bcd_ok(year_reg);

    sec_v = bcd_val(sec_b);
    min_v = bcd_val(min_b);
    hr_v  = bcd_val(hr_b);
    day_v = bcd_val(date_reg);
    mon_v = bcd_val(mon_b);
    yr_v  = bcd_val(year_reg);

    hour_ok  = twelve ? (hr_v >= 8'd1 && hr_v <= 8'd12) : (hr_v <= 8'd23);
    range_ok = (sec_v < 8'd60) && (min_v < 8'd60) && hour_ok
            && (day_v >= 8'd1) && (day_v <= 8'd31)
            && (mon_v >= 8'd1) && (mon_v <= 8'd12)
            && (yr_v >= 8'(YEAR_MIN)) && (yr_v <= 8'(YEAR_MAX));

    // 12 AM is hour 0, 12 PM stays 12, other PM hours add 12
    if (!twelve) begin
      hour24 = hr_v[4:0];
    end else if (hours_reg[5]) begin
      hour24 = (hr_v == 8'd12) ? 5'd12 : hr_v[4:0] + 5'd12;
    end else begin
      hour24 = (hr_v == 8'd12) ? 5'd0 : hr_v[4:0];
    end

    // halt bit wins over bad contents
    if (seconds_reg[7]) begin
      status1_next = ST_HALT;
    end else if (digits_ok && range_ok) begin
      status1_next = ST_OK;
    end else begin
      status1_next = ST_INVALID;
    end
  end

  logic       s1_valid;
  status_t    s1_status;
  logic [5:0] s1_sec, s1_min;
  logic [4:0] s1_hour, s1_day;
  logic [3:0] s1_mon;
  logic [6:0] s1_yr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_status <= status1_next;
    s1_sec    <= sec_v[5:0];
    s1_min    <= min_v[5:0];
    s1_hour   <= hour24;
    s1_day    <= day_v[4:0];
    s1_mon    <= mon_v[3:0];
    s1_yr     <= yr_v[6:0];
  end

  // ---------------- stage 2: day count, time of day, zone seconds ----------
  // Years 2019..2099 all sit in era 5, and year-of-era stays below 100,
  // so the century correction drops out.
  logic               mar_based_prev;
  logic [6:0]         yoe;
  logic [15:0]        days_next;
  logic [16:0]        sod_next;
  logic signed [16:0] tz_ext;
  logic signed [16:0] tz_sec_next;

  always_comb begin
    mar_based_prev = (s1_mon <= 4'd2);
    yoe = s1_yr - {6'd0, mar_based_prev};
    days_next = 16'({9'd0, yoe} * 16'd365) + {11'd0, yoe[6:2]}
              + {7'd0, doy_base(s1_mon)} + {11'd0, s1_day} - 16'd1 + DAYS_OFFSET;
    sod_next = 17'({12'd0, s1_hour} * {5'd0, SEC_PER_HOUR})
             + 17'({11'd0, s1_min} * 17'd60) + {11'd0, s1_sec};
    tz_ext = {{6{tz_offset[10]}}, tz_offset};
    tz_sec_next = tz_ext * 17'sd60;
  end

  logic               s2_valid;
  status_t            s2_status;
  logic [15:0]        s2_days;
  logic [16:0]        s2_sod;
  logic signed [16:0] s2_tz_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_status <= s1_status;
    s2_days   <= days_next;
    s2_sod    <= sod_next;
    s2_tz_sec <= tz_sec_next;
  end

  // ---------------- stage 3: days to seconds, zone-adjusted time of day ------
  logic [31:0]        day_sec_next;
  logic signed [18:0] tod_adj_next;

  always_comb begin
    day_sec_next = 32'({16'd0, s2_days} * {15'd0, SEC_PER_DAY});
    tod_adj_next = $signed({2'b00, s2_sod}) - {{2{s2_tz_sec[16]}}, s2_tz_sec};
  end

  logic               s3_valid;
  status_t            s3_status;
  logic [31:0]        s3_day_sec;
  logic signed [18:0] s3_tod_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_status  <= s2_status;
    s3_day_sec <= day_sec_next;
    s3_tod_adj <= tod_adj_next;
  end

  // ---------------- stage 4: final sum and output register ----------------
  logic [31:0] epoch_next;

  always_comb begin
    if (s3_status == ST_OK) begin
      epoch_next = s3_day_sec + {{13{s3_tod_adj[18]}}, s3_tod_adj};
    end else begin
      epoch_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    status        <= s3_status;
    epoch_seconds <= epoch_next;
  end

  // ---------------- checks ----------------
  `RTE_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##4 done)
  `RTE_ASSERT(a_no_orphan, clk, rst, done |-> $past(start, 4))
  `RTE_ASSERT(a_zero_on_error, clk, rst,
              (done && status != ST_OK) |-> (epoch_seconds == 32'd0))
  `RTE_ASSERT(a_epoch_floor, clk, rst,
              (done && status == ST_OK) |-> (epoch_seconds >= 32'd1546239420))
  `RTE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done)

endmodule

FILE: bench/rtc_registers_to_epoch_top_test.sv
`timescale 1ns / 1ps

module rtc_registers_to_epoch_top_test;
  import rte_pkg::*;

  // Pipeline depth given at the head of the top level; used for the settle
  // wait before offset writes and at the end of the run.
  localparam int LATENCY_CYCLES = 4;
  // Cycles with neither an accepted item nor a result before giving up.
  localparam int STALL_LIMIT = 5000;
  localparam int N_DIRECTED = 27;
  localparam int N_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 200;

  // One snapshot of the clock registers. When known is set, the expected
  // status/epoch are typed in the row rather than predicted.
  typedef struct packed {
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] h;
    logic [7:0] d;
    logic [7:0] mo;
    logic [7:0] y;
    logic       known;
    status_t    st;
    logic [31:0] ep;
  } snapshot_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] epoch;
  } epoch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  seconds_reg = 8'h00;
  logic [7:0]  minutes_reg = 8'h00;
  logic [7:0]  hours_reg = 8'h00;
  logic [7:0]  date_reg = 8'h01;
  logic [7:0]  month_reg = 8'h01;
  logic [7:0]  year_reg = 8'h19;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = 11'd0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] epoch_seconds;

  // Sideband that travels with each item: typed expectation, if any.
  logic          row_known = 1'b0;
  epoch_result_t row_result = '0;

  rtc_registers_to_epoch_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .seconds_reg  (seconds_reg),
    .minutes_reg  (minutes_reg),
    .hours_reg    (hours_reg),
    .date_reg     (date_reg),
    .month_reg    (month_reg),
    .year_reg     (year_reg),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .epoch_seconds(epoch_seconds)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic bit digits_ok(input logic [7:0] v);
    return (v[3:0] < 4'd10) && (v[7:4] < 4'd10);
  endfunction

  function automatic int bcd_int(input logic [7:0] v);
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  // Civil local time -> UTC epoch, days-from-civil on a March-based year.
  function automatic epoch_result_t predict_epoch(input snapshot_t r,
                                                  input logic signed [10:0] tz);
    epoch_result_t res;
    logic [7:0] sec, mins, hrs, mon;
    bit twelve, fields_ok;
    int hv;
    longint yy, era, yoe, doy, doe, days, mm, dd, hh, total;
    res.st = ST_OK;
    res.epoch = '0;
    if (r.s[7]) begin
      res.st = ST_HALT;
      return res;
    end
    sec = {1'b0, r.s[6:0]};
    mins = {1'b0, r.m[6:0]};
    mon = {3'b0, r.mo[4:0]};
    twelve = r.h[6];
    hrs = twelve ? {3'b0, r.h[4:0]} : {2'b0, r.h[5:0]};
    fields_ok = digits_ok(sec) && digits_ok(mins) && digits_ok(hrs) &&
                digits_ok(r.d) && digits_ok(mon) && digits_ok(r.y);
    if (fields_ok) begin
      hv = bcd_int(hrs);
      fields_ok = bcd_int(sec) < 60 && bcd_int(mins) < 60 &&
                  (twelve ? (hv >= 1 && hv <= 12) : (hv <= 23)) &&
                  bcd_int(r.d) >= 1 && bcd_int(r.d) <= 31 &&
                  bcd_int(mon) >= 1 && bcd_int(mon) <= 12 &&
                  bcd_int(r.y) >= 19 && bcd_int(r.y) <= 99;
    end
    if (!fields_ok) begin
      res.st = ST_INVALID;
      return res;
    end
    hh = bcd_int(hrs);
    if (twelve) begin
      if (r.h[5]) hh = (hh == 12) ? 12 : hh + 12;
      else        hh = (hh == 12) ? 0 : hh;
    end
    mm = bcd_int(mon);
    dd = bcd_int(r.d);
    yy = 2000 + bcd_int(r.y) - ((mm <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * (mm + ((mm > 2) ? -3 : 9)) + 2) / 5 + dd - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    total = days * 86400 + hh * 3600 + bcd_int(mins) * 60 + bcd_int(sec)
            - longint'(tz) * 60;
    res.epoch = 32'(total);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Directed rows: extremes, halt, each field out of range or bad BCD,
  // 12-hour corners, ignored bits, overlong February and a leap day.
  snapshot_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h19, 1'b1, ST_OK, 32'd1546300800},
    '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 1'b1, ST_OK, 32'd4102444799},
    '{8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h19, 1'b1, ST_HALT, 32'd0},
    // halt and garbage together: halt wins
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, ST_HALT, 32'd0},
    '{8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    // minutes bit 7 ignored
    '{8'h30, 8'hB0, 8'h12, 8'h15, 8'h06, 8'h25, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h1A, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    // 12 AM, 12 PM, 11 PM, 1 AM
    '{8'h00, 8'h00, 8'h52, 8'h01, 8'h01, 8'h19, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h72, 8'h01, 8'h01, 8'h19, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h71, 8'h01, 8'h01, 8'h19, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h41, 8'h01, 8'h01, 8'h19, 1'b0, ST_OK, 32'd0},
    // 12-hour mode with hour 0 or 13
    '{8'h00, 8'h00, 8'h40, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h53, 8'h01, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    // hours bit 7 ignored
    '{8'h00, 8'h00, 8'hA3, 8'h01, 8'h01, 8'h19, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h19, 1'b1, ST_INVALID, 32'd0},
    // February 31 runs on into March
    '{8'h45, 8'h30, 8'h10, 8'h31, 8'h02, 8'h23, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h19, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h19, 1'b1, ST_INVALID, 32'd0},
    // month bits 7-5 ignored
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5, 8'h19, 1'b0, ST_OK, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h18, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9A, 1'b1, ST_INVALID, 32'd0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0, 1'b1, ST_INVALID, 32'd0}
  };

  // Mostly well-formed snapshots with random content, plus halted ones
  // and ones with a single field replaced by a random byte.
  function automatic snapshot_t make_snapshot();
    snapshot_t r;
    logic [7:0] hb;
    int kind;
    r = '0;
    kind = $urandom_range(99);
    r.s = to_bcd($urandom_range(59));
    r.m = to_bcd($urandom_range(59)) | {$urandom_range(1) == 1, 7'b0};
    if ($urandom_range(1) == 1) begin
      hb = to_bcd($urandom_range(12, 1));
      r.h = {1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)), hb[4:0]};
    end else begin
      hb = to_bcd($urandom_range(23));
      r.h = {1'($urandom_range(1)), 1'b0, hb[5:0]};
    end
    r.d = to_bcd($urandom_range(31, 1));
    hb = to_bcd($urandom_range(12, 1));
    r.mo = {3'($urandom_range(7)), hb[4:0]};
    r.y = to_bcd($urandom_range(99, 19));
    if (kind >= 75 && kind < 85) begin
      r.s[7] = 1'b1;
      if ($urandom_range(1) == 1) r.h = 8'($urandom_range(255));
    end else if (kind >= 85) begin
      case ($urandom_range(5))
        0: r.s = 8'($urandom_range(255));
        1: r.m = 8'($urandom_range(255));
        2: r.h = 8'($urandom_range(255));
        3: r.d = 8'($urandom_range(255));
        4: r.mo = 8'($urandom_range(255));
        default: r.y = 8'($urandom_range(255));
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: predict on acceptance, compare on done
  // ---------------------------------------------------------------------
  epoch_result_t pending_epochs [$];
  logic signed [10:0] tz_now = 11'sd0;
  int accepted_items = 0;
  int checked_results = 0;
  int mismatches = 0;
  int ok_seen = 0;
  int halt_seen = 0;
  int invalid_seen = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    epoch_result_t want;
    snapshot_t cur;
    if (!rst) begin
      if (cfg_we) tz_now <= cfg_wdata;
      if (start && !busy) begin
        cur = '{seconds_reg, minutes_reg, hours_reg, date_reg, month_reg,
                year_reg, 1'b0, ST_OK, 32'd0};
        pending_epochs.push_back(row_known ? row_result : predict_epoch(cur, tz_now));
        accepted_items++;
      end
      if (done) begin
        if (pending_epochs.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d epoch %0d",
                   $time, status, epoch_seconds);
          mismatches++;
        end else begin
          want = pending_epochs.pop_front();
          checked_results++;
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            mismatches++;
          end
          if (epoch_seconds !== want.epoch) begin
            $display("%0t: epoch_seconds expected %0d actual %0d",
                     $time, want.epoch, epoch_seconds);
            mismatches++;
          end
          case (status)
            ST_OK:   ok_seen++;
            ST_HALT: halt_seen++;
            default: invalid_seen++;
          endcase
        end
      end
    end
  end

  // Watchdog: nothing moving for too long means the run is stuck.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress, %0d results still pending",
                 $time, pending_epochs.size());
        $display("** rtc_registers_to_epoch_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  // Present one snapshot, with random idle cycles first; returns at the
  // edge where it is taken. start stays high if the next item follows.
  task automatic drive_item(input snapshot_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      seconds_reg <= 8'($urandom_range(255));
      date_reg <= 8'($urandom_range(255));
      @(posedge clk);
    end
    start <= 1'b1;
    seconds_reg <= r.s;
    minutes_reg <= r.m;
    hours_reg <= r.h;
    date_reg <= r.d;
    month_reg <= r.mo;
    year_reg <= r.y;
    row_known <= r.known;
    row_result <= '{r.st, r.ep};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and let every pending result come back.
  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // Per phase: offset to program and how often the sender idles.
  // Phase 0 keeps the reset offset; 11-bit extremes go beyond the
  // nominal -720..840 range on purpose.
  int phase_idle [N_PHASES] = '{0, 69, 29, 0, 69, 29};
  logic signed [10:0] phase_tz [N_PHASES] = '{
    11'sd0, -11'sd720, 11'sd840, -11'sd1024, 11'sd1023, 11'sd0
  };

  initial begin
    logic signed [10:0] tz_val;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      drive_item(directed_rows[k], (k % 3 == 0) ? 50 : 0);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        tz_val = phase_tz[ph];
        if (ph == N_PHASES - 1) tz_val = 11'($signed($urandom_range(1560)) - 720);
        wait_for_quiet();
        cfg_we <= 1'b1;
        cfg_wdata <= tz_val;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // mid-phase pause: sender holds off until the pipeline drains
        if (k == ITEMS_PER_PHASE / 2) wait_for_quiet();
        drive_item(make_snapshot(), phase_idle[ph]);
      end
    end

    wait_for_quiet();
    if (pending_epochs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_epochs.size());
      mismatches++;
    end

    $display("Converted %0d snapshots (%0d directed) over %0d time-zone offsets;",
             accepted_items, N_DIRECTED, N_PHASES);
    $display("results checked %0d: ok %0d, halted %0d, invalid %0d; mismatches %0d",
             checked_results, ok_seen, halt_seen, invalid_seen, mismatches);
    if (mismatches == 0) begin
      $display("** rtc_registers_to_epoch_top: PASSED **");
    end else begin
      $display("** rtc_registers_to_epoch_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/rte_pkg.sv
src/rtc_registers_to_epoch_top.sv
bench/rtc_registers_to_epoch_top_test.sv
